@@ rtl/core/dlss_pkg.sv @@
// Package of the delay layer spike scheduler: field widths, status codes,
// register indexes, reset values and the stored spike record.
// Depends on nothing; used by the scheduler top level.
package dlss_pkg;

   localparam int LayerBits    = 4;
   localparam int NeuronBits   = 16;
   localparam int TimeBits     = 32;
   localparam int LayersCfgBits = 5;
   localparam int StepBits     = 20;

   localparam int DefMaxLayers  = 16;
   localparam int DefQueueDepth = 256;

   localparam logic [LayersCfgBits-1:0] LayersReset = 5'd16;
   localparam logic [StepBits-1:0]      StepReset   = 20'd1024;

   localparam logic CsrLayersInUse = 1'b0;
   localparam logic CsrDelayStep   = 1'b1;

   localparam logic [1:0] StatusExternal = 2'd0;
   localparam logic [1:0] StatusInternal = 2'd1;
   localparam logic [1:0] StatusPushed   = 2'd2;
   localparam logic [1:0] StatusDropped  = 2'd3;

   localparam logic KindPush = 1'b0;
   localparam logic KindPop  = 1'b1;

   typedef struct packed {
      logic [NeuronBits-1:0] neuron;
      logic [TimeBits-1:0]   stime;
      logic [TimeBits-1:0]   interval;
   } spike_type;

endpackage

@@ rtl/core/delay_layer_spike_scheduler_unit.sv @@
// Top level of the delay layer spike scheduler: sequencer over head, queue
// state and queue memories. Depends on dlss_pkg and dlss_ram.
//
// Usage
//   req_*  : one request per item. req_tuser = kind (0 push, 1 pop).
//            A push loads a spike into a layer; a pop carries the next
//            external spike time and asks which event comes first.
//   rsp_*  : one result per request. rsp_tuser = status.
//   csr_*  : register writes (index 0 layers_in_use, 1 delay_step), always
//            taken; write them only while no request is in flight.
// Timing
//   A push dropped for an unused layer goes straight to its result, others
//   go through the head or the queue state. A pop gives an external-first
//   answer after the search, a delivered spike after any forwarding and the
//   queue advance: the search reads one head a cycle over the layers in use,
//   and forwarding and queue advance are read, modify, write passes over the state memories.
//   One request is worked on at a time; the next is taken once the sequencer
//   is idle, even while the last result still waits.
// Reset
//   Synchronous reset clears all head and queue-state valid bits and the
//   registers take their reset values. No clearing pass is needed.
// Stall
//   A stalled result holds in the output register; a finished request
//   waits in the sequencer until that register is free.
module delay_layer_spike_scheduler_unit #(
   parameter int MAX_LAYERS  = dlss_pkg::DefMaxLayers,
   parameter int QUEUE_DEPTH = dlss_pkg::DefQueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   // tdata: target_layer[3:0], neuron_id[19:4], spike_time[51:20],
   //        interval[83:52], external_time[115:84], zero fill
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,
   input  logic [0:0]   req_tuser,  // kind[0]
   // tdata: from_layer[3:0], out_neuron[19:4], out_time[51:20],
   //        out_interval[83:52], forward_dropped[84], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,  // status[1:0]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [19:0]  csr_wdata
);

   localparam int LW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int NW  = $clog2(MAX_LAYERS + 1);
   localparam int SW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int MW  = CW + SW;
   localparam int SPW = $bits(dlss_pkg::spike_type);
   localparam int TB  = dlss_pkg::TimeBits;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_LOAD     = 4'd1;
   localparam logic [3:0] ST_LOAD_Q   = 4'd2;
   localparam logic [3:0] ST_SCAN     = 4'd3;
   localparam logic [3:0] ST_DECIDE   = 4'd4;
   localparam logic [3:0] ST_ADV      = 4'd5;
   localparam logic [3:0] ST_ADV_Q    = 4'd6;
   localparam logic [3:0] ST_ADV_HEAD = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   // registers
   logic [3:0]                  state_ff, state_in;
   logic [4:0]                  layers_ff;
   logic [19:0]                 step_ff;
   logic [MAX_LAYERS-1:0]       head_valid_ff, head_valid_in;
   logic [MAX_LAYERS-1:0]       meta_valid_ff, meta_valid_in;
   logic [LW-1:0]               ld_layer_ff, ld_layer_in;
   dlss_pkg::spike_type         ld_data_ff, ld_data_in;
   logic                        ld_fwd_ff, ld_fwd_in;
   logic [NW-1:0]               scan_idx_ff, scan_idx_in;
   logic                        chk_ff, chk_in;
   logic [LW-1:0]               chk_idx_ff, chk_idx_in;
   logic                        found_ff, found_in;
   logic [LW-1:0]               best_layer_ff, best_layer_in;
   dlss_pkg::spike_type         best_ff, best_in;
   logic [TB-1:0]               ext_ff, ext_in;
   logic [1:0]                  res_status_ff, res_status_in;
   logic                        res_fwd_ff, res_fwd_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [87:0]                 rsp_data_ff, rsp_data_in;

   // memory ports
   logic                        head_we;
   logic [LW-1:0]               head_waddr, head_raddr;
   dlss_pkg::spike_type         head_wdata, head_rdata;
   logic                        meta_we;
   logic [LW-1:0]               meta_waddr, meta_raddr;
   logic [MW-1:0]               meta_wdata, meta_rdata;
   logic                        fifo_we;
   logic [LW+SW-1:0]            fifo_waddr, fifo_raddr;
   dlss_pkg::spike_type         fifo_wdata, fifo_rdata;

   logic [NW-1:0]               n_used;
   logic [CW-1:0]               q_count;
   logic [SW-1:0]               q_ptr;
   logic [SW:0]                 wr_sum;
   logic [SW-1:0]               wr_slot;
   logic [SW-1:0]               ptr_next;
   logic [TB:0]                 sat_sum;
   logic [TB-1:0]               fwd_time;
   logic [NW:0]                 next_layer;
   logic                        meta_ok;

   dlss_ram #(.WIDTH(SPW), .DEPTH(2 ** LW)) u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
      .rd_addr(head_raddr), .rd_data(head_rdata)
   );

   dlss_ram #(.WIDTH(MW), .DEPTH(2 ** LW)) u_meta_ram (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_waddr), .wr_data(meta_wdata),
      .rd_addr(meta_raddr), .rd_data(meta_rdata)
   );

   dlss_ram #(.WIDTH(SPW), .DEPTH((2 ** LW) * (2 ** SW))) u_fifo_ram (
      .clock(clock), .wr_en(fifo_we), .wr_addr(fifo_waddr), .wr_data(fifo_wdata),
      .rd_addr(fifo_raddr), .rd_data(fifo_rdata)
   );

   // Effective layer count: zero acts as one, clamp at the built maximum.
   always_comb begin
      if (layers_ff == 5'd0) begin
         n_used = NW'(1);
      end else if (int'(layers_ff) > MAX_LAYERS) begin
         n_used = NW'(MAX_LAYERS);
      end else begin
         n_used = NW'(layers_ff);
      end
   end

   // Queue state read back; a never written entry reads as empty.
   always_comb begin
      meta_ok  = meta_valid_ff[meta_raddr];
      q_count  = meta_ok ? meta_rdata[MW-1:SW] : '0;
      q_ptr    = meta_ok ? meta_rdata[SW-1:0] : '0;
      wr_sum   = (SW+1)'(q_ptr) + (SW+1)'(q_count);
      wr_slot  = (wr_sum >= (SW+1)'(QUEUE_DEPTH)) ?
                 SW'(wr_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(wr_sum);
      ptr_next = (q_ptr == SW'(QUEUE_DEPTH - 1)) ? '0 : q_ptr + SW'(1);
   end

   // Saturating time advance for the forwarded copy.
   always_comb begin
      sat_sum    = (TB+1)'(best_ff.stime) + (TB+1)'(step_ff);
      fwd_time   = sat_sum[TB] ? '1 : sat_sum[TB-1:0];
      next_layer = (NW+1)'(best_layer_ff) + (NW+1)'(1);
   end

   always_comb begin
      state_in      = state_ff;
      head_valid_in = head_valid_ff;
      meta_valid_in = meta_valid_ff;
      ld_layer_in   = ld_layer_ff;
      ld_data_in    = ld_data_ff;
      ld_fwd_in     = ld_fwd_ff;
      scan_idx_in   = scan_idx_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      best_layer_in = best_layer_ff;
      best_in       = best_ff;
      ext_in        = ext_ff;
      res_status_in = res_status_ff;
      res_fwd_in    = res_fwd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      head_we    = 1'b0;
      head_waddr = ld_layer_ff;
      head_wdata = ld_data_ff;
      head_raddr = LW'(scan_idx_ff);
      meta_we    = 1'b0;
      meta_waddr = ld_layer_ff;
      meta_wdata = {CW'(q_count + CW'(1)), q_ptr};
      meta_raddr = ld_layer_ff;
      fifo_we    = 1'b0;
      fifo_waddr = {ld_layer_ff, wr_slot};
      fifo_wdata = ld_data_ff;
      fifo_raddr = {best_layer_ff, q_ptr};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == dlss_pkg::KindPush) begin
                  ld_layer_in = LW'(req_tdata[3:0]);
                  ld_data_in  = '{neuron: req_tdata[19:4], stime: req_tdata[51:20],
                                  interval: req_tdata[83:52]};
                  ld_fwd_in   = 1'b0;
                  if (32'(req_tdata[3:0]) >= 32'(n_used)) begin
                     res_status_in = dlss_pkg::StatusDropped;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  ext_in      = req_tdata[115:84];
                  scan_idx_in = '0;
                  found_in    = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_LOAD: begin
            // empty head: fill it directly, else go through the queue state
            if (!head_valid_ff[ld_layer_ff]) begin
               head_we                    = 1'b1;
               head_valid_in[ld_layer_ff] = 1'b1;
               if (ld_fwd_ff) begin
                  res_fwd_in = 1'b0;
                  state_in   = ST_ADV;
               end else begin
                  res_status_in = dlss_pkg::StatusPushed;
                  state_in      = ST_DONE;
               end
            end else begin
               state_in = ST_LOAD_Q;
            end
         end
         ST_LOAD_Q: begin
            if (32'(q_count) >= QUEUE_DEPTH) begin
               res_fwd_in    = 1'b1;
               res_status_in = dlss_pkg::StatusDropped;
            end else begin
               fifo_we                    = 1'b1;
               meta_we                    = 1'b1;
               meta_valid_in[ld_layer_ff] = 1'b1;
               res_fwd_in                 = 1'b0;
               res_status_in              = dlss_pkg::StatusPushed;
            end
            state_in = ld_fwd_ff ? ST_ADV : ST_DONE;
         end
         ST_SCAN: begin
            // issue one head read a cycle, compare the one read last cycle
            if (chk_ff && head_valid_ff[chk_idx_ff] &&
                (!found_ff || head_rdata.stime < best_ff.stime)) begin
               found_in      = 1'b1;
               best_layer_in = chk_idx_ff;
               best_in       = head_rdata;
            end
            if (scan_idx_ff < n_used) begin
               chk_in      = 1'b1;
               chk_idx_in  = LW'(scan_idx_ff);
               scan_idx_in = scan_idx_ff + NW'(1);
            end else if (!chk_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!found_ff || ext_ff <= best_ff.stime) begin
               res_status_in = dlss_pkg::StatusExternal;
               state_in      = ST_DONE;
            end else begin
               res_status_in = dlss_pkg::StatusInternal;
               res_fwd_in    = 1'b0;
               if (next_layer < (NW+1)'(n_used)) begin
                  ld_layer_in = LW'(next_layer);
                  ld_data_in  = '{neuron: best_ff.neuron, stime: fwd_time,
                                  interval: best_ff.interval};
                  ld_fwd_in   = 1'b1;
                  state_in    = ST_LOAD;
               end else begin
                  state_in = ST_ADV;
               end
            end
         end
         ST_ADV: begin
            meta_raddr = best_layer_ff;
            state_in   = ST_ADV_Q;
         end
         ST_ADV_Q: begin
            // advance the delivering layer: next queued spike or empty head
            meta_raddr = best_layer_ff;
            if (q_count == '0) begin
               head_valid_in[best_layer_ff] = 1'b0;
               state_in                     = ST_DONE;
            end else begin
               meta_we    = 1'b1;
               meta_waddr = best_layer_ff;
               meta_wdata = {CW'(q_count - CW'(1)), ptr_next};
               state_in   = ST_ADV_HEAD;
            end
            res_status_in = dlss_pkg::StatusInternal;
         end
         ST_ADV_HEAD: begin
            head_we    = 1'b1;
            head_waddr = best_layer_ff;
            head_wdata = fifo_rdata;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == dlss_pkg::StatusInternal) begin
                  rsp_data_in = {3'b000, res_fwd_ff, best_ff.interval, best_ff.stime,
                                 best_ff.neuron, 4'(best_layer_ff)};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         layers_ff     <= dlss_pkg::LayersReset;
         step_ff       <= dlss_pkg::StepReset;
         head_valid_ff <= '0;
         meta_valid_ff <= '0;
         chk_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         meta_valid_ff <= meta_valid_in;
         chk_ff        <= chk_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               dlss_pkg::CsrLayersInUse: layers_ff <= csr_wdata[4:0];
               dlss_pkg::CsrDelayStep:   step_ff   <= csr_wdata;
               default:                  layers_ff <= layers_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ld_layer_ff   <= ld_layer_in;
      ld_data_ff    <= ld_data_in;
      ld_fwd_ff     <= ld_fwd_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      best_layer_ff <= best_layer_in;
      best_ff       <= best_in;
      ext_ff        <= ext_in;
      res_status_ff <= res_status_in;
      res_fwd_ff    <= res_fwd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // only a delivered spike carries payload
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != dlss_pkg::StatusInternal |-> rsp_tdata == '0)
      else $error("payload not zero on a non-delivery result");

   // reset empties every head
   a_reset_heads: assert property (@(posedge clock)
      reset |=> head_valid_ff == '0)
      else $error("head valid bits not cleared by reset");

   // the search never runs past the layers in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_idx_ff <= n_used)
      else $error("layer search index out of range");

endmodule

@@ rtl/core/dlss_ram.sv @@
// Generic simple dual port RAM: one write port, one registered read port.
// Depends on nothing.
module dlss_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/delay_layer_spike_scheduler_unit_tb.sv @@
// Self-checking bench for the delay layer spike scheduler: predicts each result
// from its own layer/queue model and checks the result stream field by field.
// Depends on dlss_pkg and the scheduler top level.
module delay_layer_spike_scheduler_unit_tb;

   localparam int NumLayers = dlss_pkg::DefMaxLayers;
   localparam int QDepth    = dlss_pkg::DefQueueDepth;
   localparam int WatchLimit = 20000;

   typedef struct {
      logic [1:0]                      status;
      logic [dlss_pkg::LayerBits-1:0]  layer;
      logic [dlss_pkg::NeuronBits-1:0] neuron;
      logic [dlss_pkg::TimeBits-1:0]   stime;
      logic [dlss_pkg::TimeBits-1:0]   interval;
      logic                            fwd_drop;
   } event_type;

   // Scheduler model and the queue of results it has predicted.
   class spike_scoreboard;
      logic [4:0]                    layers_cfg;
      logic [dlss_pkg::StepBits-1:0] step_cfg;
      bit                            head_ok [NumLayers];
      dlss_pkg::spike_type           head [NumLayers];
      dlss_pkg::spike_type           queue [NumLayers][$];
      event_type                     pending [$];
      int                            errors;

      function new();
         layers_cfg = dlss_pkg::LayersReset;
         step_cfg   = dlss_pkg::StepReset;
         errors     = 0;
         foreach (head_ok[i]) head_ok[i] = 0;
      endfunction

      function int active_layers();
         if (layers_cfg == 0) return 1;
         if (int'(layers_cfg) > NumLayers) return NumLayers;
         return int'(layers_cfg);
      endfunction

      function bit store_spike(int l, dlss_pkg::spike_type s);
         if (!head_ok[l]) begin
            head_ok[l] = 1;
            head[l] = s;
            return 1;
         end
         if (queue[l].size() >= QDepth) return 0;
         queue[l].push_back(s);
         return 1;
      endfunction

      function void note_request(logic kind, logic [119:0] d);
         event_type           e;
         dlss_pkg::spike_type s;
         int                  oldest;
         logic [32:0]         sum;
         e = '{default: '0};
         if (kind == dlss_pkg::KindPush) begin
            s.neuron   = d[19:4];
            s.stime    = d[51:20];
            s.interval = d[83:52];
            if (int'(d[3:0]) >= active_layers()) e.status = dlss_pkg::StatusDropped;
            else e.status = store_spike(int'(d[3:0]), s) ? dlss_pkg::StatusPushed
                                                         : dlss_pkg::StatusDropped;
         end else begin
            oldest = -1;
            for (int i = 0; i < active_layers(); i++)
               if (head_ok[i] && (oldest < 0 || head[i].stime < head[oldest].stime))
                  oldest = i;
            if (oldest < 0 || d[115:84] <= head[oldest].stime) begin
               e.status = dlss_pkg::StatusExternal;
            end else begin
               s = head[oldest];
               e.status = dlss_pkg::StatusInternal;
               e.layer = oldest[dlss_pkg::LayerBits-1:0];
               e.neuron = s.neuron;
               e.stime = s.stime;
               e.interval = s.interval;
               if (oldest + 1 < active_layers()) begin
                  dlss_pkg::spike_type f;
                  f = s;
                  sum = {1'b0, s.stime} + 33'(step_cfg);
                  f.stime = sum[32] ? '1 : sum[31:0];
                  e.fwd_drop = !store_spike(oldest + 1, f);
               end
               if (queue[oldest].size() == 0) head_ok[oldest] = 0;
               else head[oldest] = queue[oldest].pop_front();
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(logic [1:0] st, logic [87:0] d);
         event_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: status %0d", st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st); errors++;
         end
         if (d[3:0] !== e.layer) begin
            $error("from_layer: expected %0d, got %0d", e.layer, d[3:0]); errors++;
         end
         if (d[19:4] !== e.neuron) begin
            $error("out_neuron: expected %0h, got %0h", e.neuron, d[19:4]); errors++;
         end
         if (d[51:20] !== e.stime) begin
            $error("out_time: expected %0h, got %0h", e.stime, d[51:20]); errors++;
         end
         if (d[83:52] !== e.interval) begin
            $error("out_interval: expected %0h, got %0h", e.interval, d[83:52]); errors++;
         end
         if (d[84] !== e.fwd_drop) begin
            $error("forward_dropped: expected %0b, got %0b", e.fwd_drop, d[84]); errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [87:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_index = 0;
   logic [19:0]  csr_wdata = '0;

   spike_scoreboard board = new();
   int  idle_cycles = 0;
   bit  gaps_on = 1;
   logic [31:0] clock_now = 0;   // coarse running time used to build sane spike times

   always #5 clock = ~clock;

   delay_layer_spike_scheduler_unit DUT (.*);

   // Mostly short gaps, now and then a long one; none while gaps are off.
   function int pick_gap();
      if (!gaps_on) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0;
   endfunction

   // Check results and drive the random stall on the result side.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata);
         if (gaps_on) rsp_tready <= ($urandom_range(0, 3) != 0);
         else rsp_tready <= 1;
      end
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Valid stays high after an accept; drop it only ahead of a gap or a pause.
   task automatic send_request(logic kind, logic [3:0] layer, logic [15:0] nrn,
                               logic [31:0] st, logic [31:0] isi, logic [31:0] ext);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, ext, isi, st, nrn, layer};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, {4'b0, ext, isi, st, nrn, layer});
   endtask

   task automatic push_spike(logic [3:0] layer, logic [15:0] nrn, logic [31:0] st,
                             logic [31:0] isi);
      send_request(dlss_pkg::KindPush, layer, nrn, st, isi, $urandom);
   endtask

   task automatic pop_event(logic [31:0] ext);
      send_request(dlss_pkg::KindPop, 4'($urandom), 16'($urandom), $urandom, $urandom,
                   ext);
   endtask

   // Drain all results, let the sequencer settle, then write one register.
   task automatic write_register(logic idx, logic [19:0] val);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == dlss_pkg::CsrLayersInUse) board.layers_cfg = val[4:0];
      else board.step_cfg = val;
   endtask

   // One random phase: mostly plausible traffic around a moving clock.
   task automatic random_phase(int count, int time_span);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         clock_now += $urandom_range(0, time_span);
         if (r < 45)
            push_spike(4'($urandom_range(0, 15)) & (r < 40 ? 4'h3 : 4'hF),
                       16'($urandom), clock_now + $urandom_range(0, time_span),
                       $urandom);
         else if (r < 90)
            pop_event(clock_now + $urandom_range(0, 4 * time_span));
         else if (r < 95)
            push_spike(4'($urandom), 16'($urandom), $urandom, $urandom);
         else
            pop_event($urandom);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty pop, field extremes, ties, layer order, saturation.
      pop_event(32'hFFFF_FFFF);
      push_spike(4'd0, 16'hFFFF, 32'hFFFF_FC00, 32'hFFFF_FFFF);
      push_spike(4'd15, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      push_spike(4'd3, 16'h1234, 32'h0000_0000, 32'hA5A5_5A5A);
      pop_event(32'h0);                  // external ties the oldest head
      pop_event(32'h1);                  // lowest layer wins the tie at zero
      pop_event(32'h1);
      pop_event(32'hFFFF_FFFF);          // delivers the copy forwarded into layer 4
      pop_event(32'hFFFF_FFFF);
      pop_event(32'hFFFF_FFFF);
      write_register(dlss_pkg::CsrLayersInUse, 20'd2);
      push_spike(4'd2, 16'h0001, 32'h10, 32'h1);   // above the count: dropped
      write_register(dlss_pkg::CsrLayersInUse, 20'd0);   // zero behaves as one
      push_spike(4'd0, 16'h0002, 32'h20, 32'h2);
      push_spike(4'd1, 16'h0003, 32'h30, 32'h3);
      pop_event(32'hFFFF_FFFF);                    // last layer: no forward
      write_register(dlss_pkg::CsrLayersInUse, 20'd31);  // above the maximum acts as 16
      write_register(dlss_pkg::CsrDelayStep, 20'hFFFFF);
      pop_event(32'hFFFF_FFFF);

      // Fill one queue to overflow, then forward into the full layer.
      write_register(dlss_pkg::CsrLayersInUse, 20'd2);
      for (int i = 0; i < QDepth + 2; i++)
         push_spike(4'd1, 16'(i), 32'h8000_0000 + 32'(i), 32'(i));
      push_spike(4'd0, 16'hBEEF, 32'h100, 32'h7);
      pop_event(32'h200);
      for (int i = 0; i < 40; i++) pop_event(32'hFFFF_FFFF);

      // Random phases across settings; the model keeps the leftover spikes.
      for (int p = 0; p < 6; p++) begin
         gaps_on = (p != 3);
         write_register(dlss_pkg::CsrLayersInUse, (p == 0) ? 20'd16 : (p == 1) ? 20'd1
                                       : 20'($urandom_range(1, 16)));
         write_register(dlss_pkg::CsrDelayStep, (p == 2) ? 20'd0 : (p == 4) ? 20'hFFFFF
                                     : 20'($urandom_range(0, 4096)));
         random_phase(140, 2000);
      end
      gaps_on = 1;
      random_phase(150, 1 << 20);

      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
